>>> src/tpager_pkg.sv
// Shared types and constants for the terminal output pager.
// Used by every module of the block; depends on nothing.
package tpager_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned QDEPTH   = 4;
   localparam int unsigned QPTR_W   = $clog2(QDEPTH);
   localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

   localparam logic [BYTE_W-1:0] ROWS_RESET = 8'd25;
   localparam logic [BYTE_W-1:0] COLS_RESET = 8'd80;

   localparam logic [BYTE_W-1:0] CH_QUIT    = 8'h71; // 'q'
   localparam logic [BYTE_W-1:0] CH_NEXT    = 8'h6E; // 'n'
   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_PROMPT  = 8'h3A; // ':'
   localparam logic [BYTE_W-1:0] CH_BACKSP  = 8'h08;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_KEY  = 2'd1,
      MODE_LOST = 2'd2,
      MODE_RSVD = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_STOPPED  = 2'd1,
      ST_HELD     = 2'd2,
      ST_IGNORED  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_SCREEN_ROWS    = 1'b0,
      CSR_SCREEN_COLUMNS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_SINGLE     = 2'd0,
      CMD_ERASE      = 2'd1,
      CMD_ERASE_BYTE = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic              emit;
      logic [BYTE_W-1:0] out_byte;
      logic [1:0]        status;
      logic              last;
   } rsp_type;

   // Command passed from front to back.
   typedef struct packed {
      cmd_kind_type      kind;
      logic              emit;
      logic [BYTE_W-1:0] out_byte;
      status_type        status;
   } cmd_type;

endpackage

>>> src/tpager_front.sv
// Front end: accepts input transfers, keeps row/column/prompt state and
// the screen size registers, and turns each item into one command.
// Depends on tpager_pkg.
module tpager_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  tpager_pkg::req_type        req_data,
   input  logic                       csr_wr_en,
   input  logic [0:0]                 csr_index,
   input  logic [tpager_pkg::BYTE_W-1:0] csr_wdata,
   input  logic                       q_full,
   output logic                       q_push,
   output tpager_pkg::cmd_type        q_data
);

   typedef struct packed {
      logic [tpager_pkg::BYTE_W-1:0] row;
      logic [tpager_pkg::BYTE_W-1:0] col;
      logic                          full;
   } cnt_type;

   logic [tpager_pkg::BYTE_W-1:0] rows_ff, cols_ff;
   logic [tpager_pkg::BYTE_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [tpager_pkg::BYTE_W-1:0] held_ff, held_in;
   logic full_ff, full_in, stopped_ff, stopped_in, awaiting_ff, awaiting_in;
   logic accept;
   cnt_type cnt_text, cnt_held;
   logic [tpager_pkg::BYTE_W-1:0] b;
   logic go_key;

   // Advance counts for one shown byte.
   function automatic cnt_type count_byte(
      input logic [tpager_pkg::BYTE_W-1:0] row,
      input logic [tpager_pkg::BYTE_W-1:0] col,
      input logic [tpager_pkg::BYTE_W-1:0] rows,
      input logic [tpager_pkg::BYTE_W-1:0] cols,
      input logic [tpager_pkg::BYTE_W-1:0] ch);
      cnt_type r;
      logic [tpager_pkg::BYTE_W-1:0] c1;
      logic bump;
      c1 = col + 8'd1;
      bump = (ch == tpager_pkg::CH_NEWLINE) || (c1 >= cols);
      r.row = row;
      r.col = c1;
      if (bump) begin
         if (row != 8'hFF) r.row = row + 8'd1;
         r.col = '0;
      end
      r.full = (rows == 8'd0) || (r.row >= rows - 8'd1);
      return r;
   endfunction

   assign accept = req_push && !q_full;
   assign b      = req_data.data_byte;
   assign go_key = (b == tpager_pkg::CH_NEXT) || (b == tpager_pkg::CH_SPACE) ||
                   (b == tpager_pkg::CH_NEWLINE);
   assign cnt_text = count_byte(row_ff, col_ff, rows_ff, cols_ff, b);
   assign cnt_held = count_byte('0, '0, rows_ff, cols_ff, held_ff);

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      full_in     = full_ff;
      stopped_in  = stopped_ff;
      awaiting_in = awaiting_ff;
      held_in     = held_ff;
      q_push      = accept;
      q_data.kind     = tpager_pkg::CMD_SINGLE;
      q_data.emit     = 1'b0;
      q_data.out_byte = '0;
      q_data.status   = tpager_pkg::ST_IGNORED;
      if (stopped_ff) begin
         q_data.status = tpager_pkg::ST_STOPPED;
      end else if (req_data.mode == tpager_pkg::MODE_TEXT) begin
         if (awaiting_ff) begin
            q_data.status = tpager_pkg::ST_STOPPED;
         end else if (full_ff) begin
            held_in         = b;
            awaiting_in     = 1'b1;
            q_data.emit     = 1'b1;
            q_data.out_byte = tpager_pkg::CH_PROMPT;
            q_data.status   = tpager_pkg::ST_HELD;
         end else begin
            q_data.emit     = 1'b1;
            q_data.out_byte = b;
            q_data.status   = tpager_pkg::ST_ACCEPTED;
            row_in  = cnt_text.row;
            col_in  = cnt_text.col;
            full_in = full_ff || cnt_text.full;
         end
      end else if (awaiting_ff && (req_data.mode == tpager_pkg::MODE_KEY ||
                                   req_data.mode == tpager_pkg::MODE_LOST)) begin
         if (req_data.mode == tpager_pkg::MODE_LOST || b == tpager_pkg::CH_QUIT) begin
            stopped_in    = 1'b1;
            awaiting_in   = 1'b0;
            row_in        = '0;
            col_in        = '0;
            full_in       = 1'b0;
            q_data.kind   = tpager_pkg::CMD_ERASE;
            q_data.status = tpager_pkg::ST_STOPPED;
         end else if (go_key) begin
            awaiting_in     = 1'b0;
            row_in          = cnt_held.row;
            col_in          = cnt_held.col;
            full_in         = cnt_held.full;
            q_data.kind     = tpager_pkg::CMD_ERASE_BYTE;
            q_data.emit     = 1'b1;
            q_data.out_byte = held_ff;
            q_data.status   = tpager_pkg::ST_ACCEPTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= tpager_pkg::ROWS_RESET;
         cols_ff     <= tpager_pkg::COLS_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         full_ff     <= 1'b0;
         stopped_ff  <= 1'b0;
         awaiting_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               tpager_pkg::CSR_SCREEN_ROWS:    rows_ff <= csr_wdata;
               tpager_pkg::CSR_SCREEN_COLUMNS: cols_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            row_ff      <= row_in;
            col_ff      <= col_in;
            full_ff     <= full_in;
            stopped_ff  <= stopped_in;
            awaiting_ff <= awaiting_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) held_ff <= held_in;
   end

endmodule

>>> src/tpager_queue.sv
// Short command queue between front and back ends.
// Depends on tpager_pkg.
module tpager_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpager_pkg::cmd_type push_data,
   output logic                full,
   input  logic                pop,
   output tpager_pkg::cmd_type head_data,
   output logic                empty
);

   tpager_pkg::cmd_type slot_ff [tpager_pkg::QDEPTH];
   logic [tpager_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [tpager_pkg::QCNT_W-1:0] cnt_ff;
   logic do_push, do_pop;

   assign full      = (cnt_ff == tpager_pkg::QCNT_W'(tpager_pkg::QDEPTH));
   assign empty     = (cnt_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

endmodule

>>> src/tpager_back.sv
// Back end: expands each command into its result transfers and holds the
// current result in an output register. Depends on tpager_pkg.
module tpager_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  tpager_pkg::cmd_type cmd,
   output logic                cmd_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output tpager_pkg::rsp_type rsp_data
);

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   tpager_pkg::rsp_type out_ff, out_in, gen;
   logic out_ready;

   // Result for the current step of the command at the queue head.
   always_comb begin
      gen.emit     = 1'b1;
      gen.out_byte = (step_ff == 2'd1) ? tpager_pkg::CH_SPACE : tpager_pkg::CH_BACKSP;
      gen.status   = cmd.status;
      gen.last     = 1'b0;
      case (cmd.kind)
         tpager_pkg::CMD_SINGLE: begin
            gen.emit     = cmd.emit;
            gen.out_byte = cmd.out_byte;
            gen.last     = 1'b1;
         end
         tpager_pkg::CMD_ERASE: begin
            gen.last = (step_ff == 2'd2);
         end
         default: begin
            if (step_ff == 2'd3) begin
               gen.out_byte = cmd.out_byte;
               gen.last     = 1'b1;
            end
         end
      endcase
   end

   assign out_ready = !valid_ff || rsp_pop;
   assign cmd_pop   = cmd_valid && out_ready && gen.last;
   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (cmd_valid && out_ready) begin
         valid_in = 1'b1;
         out_in   = gen;
         step_in  = gen.last ? 2'd0 : step_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

>>> src/terminal_output_pager_top.sv
// Top level of the terminal output pager: front end, command queue, back end.
// Depends on tpager_pkg, tpager_front, tpager_queue and tpager_back.
//
// Usage:
//   Input channel (req_*): push an item (mode, data_byte) while req_full is
//   low; a transfer happens on each clock edge with req_push high and
//   req_full low. Text bytes, reader keys and lost-input events all go here.
//   Result channel (rsp_*): while rsp_empty is low, rsp_data holds the oldest
//   result; raising rsp_pop takes it. Each item yields one result, or four
//   when the prompt is erased (three when the pager stops); the final result
//   of an item has last set.
//   Config port (csr_*): index 0 screen_rows, 1 screen_columns; write only
//   while the block is idle.
// Path: a single-result item is registered in a queue slot, then in the output
//   register, before it shows on rsp_data.
// Throughput: one item per cycle for single-result items while rsp_pop keeps
//   up; an erase sequence holds the back end until its three or four results
//   are out, one result per cycle, set by the back end's output register.
// Reset: clears counts, prompt and stop state, empties the queue and output,
//   and loads 25 rows by 80 columns.
// Receiver stall: results wait in the output register, commands pile up in
//   the four-entry queue, and req_full rises once the queue is full.
module terminal_output_pager_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  tpager_pkg::req_type           req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output tpager_pkg::rsp_type           rsp_data,
   input  logic                          csr_wr_en,
   input  logic [0:0]                    csr_index,
   input  logic [tpager_pkg::BYTE_W-1:0] csr_wdata
);

   logic                q_push, q_full, q_pop, q_empty;
   tpager_pkg::cmd_type q_in, q_head;

   assign req_full = q_full;

   // Front end: classifies each transfer against the page state.
   tpager_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   // Decouples front from back so either can stall on its own.
   tpager_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty)
   );

   // Back end: one result per cycle into the output register while rsp_pop keeps up.
   tpager_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
